>>> rtl/lbbr_pkg.sv
// Shared constants and types for the longest balanced bracket run block.
`default_nettype none

package lbbr_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 1024;
	localparam int unsigned MAX_LEN_DEF     = 65536;

	localparam int unsigned CH_W       = 8;
	localparam int unsigned BEST_LEN_W = 17;
	localparam int unsigned BEST_POS_W = 16;

	localparam logic [CH_W-1:0] OPEN_BYTE = 8'd40;

	// stack control from the step logic to the stack
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stack_cmd_t;

endpackage

`default_nettype wire

>>> rtl/lbbr_if.sv
// Valid/ready channel interfaces for characters in and results out.
`default_nettype none

interface lbbr_in_if import lbbr_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

interface lbbr_out_if import lbbr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [BEST_LEN_W-1:0] best_len;
	logic [BEST_POS_W-1:0] best_start;
	logic [BEST_POS_W-1:0] best_end;
	logic                  done_res;
	logic                  overflow;

	modport source (output valid, output best_len, output best_start, output best_end,
		output done_res, output overflow, input ready);
	modport sink (input valid, input best_len, input best_start, input best_end,
		input done_res, input overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/lbbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lbbr_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/lbbr_stack.sv
// Open-bracket position stack: RAM body with the top two entries cached in registers.
`default_nettype none

module lbbr_stack import lbbr_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int unsigned POS_W       = 16,
	localparam int unsigned CNT_W      = $clog2(STACK_DEPTH + 1),
	localparam int unsigned AW         = $clog2(STACK_DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire stack_cmd_t       cmd,
	input  wire logic [POS_W-1:0] push_data,
	output logic      [CNT_W-1:0] count,
	output logic      [POS_W-1:0] below_top
);

	logic [CNT_W-1:0] count_q, count_d;
	logic [POS_W-1:0] top_q, top_d;
	logic [POS_W-1:0] below_q, below_d;
	logic [POS_W-1:0] third;
	logic [CNT_W-1:0] raddr_full;

	// third-from-top is prefetched: read address follows the next count
	always_comb begin
		count_d = count_q;
		top_d   = top_q;
		below_d = below_q;
		if (cmd.push) begin
			count_d = count_q + CNT_W'(1);
			top_d   = push_data;
			below_d = top_q;
		end else if (cmd.pop) begin
			count_d = count_q - CNT_W'(1);
			top_d   = below_q;
			below_d = third;
		end
		if (cmd.clear) begin
			count_d = '0;
		end
		raddr_full = (count_d >= CNT_W'(3)) ? (count_d - CNT_W'(3)) : '0;
	end

	lbbr_ram #(
		.WIDTH (POS_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (count_q[AW-1:0]),
		.wdata (push_data),
		.raddr (raddr_full[AW-1:0]),
		.rdata (third)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q   <= top_d;
		below_q <= below_d;
	end

	assign count     = count_q;
	assign below_top = below_q;

endmodule

`default_nettype wire

>>> rtl/longest_balanced_bracket_run_top.sv
// Top level of the longest balanced bracket run block.
//
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+-------------
//  chars    | in  | ch[7:0], last                                  | valid/ready
//  results  | out | best_len[16:0], best_start, best_end, done_res, | valid/ready
//           |     | overflow                                       |
//
// One item per cycle while results are taken: each character updates all state
// in the cycle it is accepted and its result is registered for the next cycle.
// The stack top and the entry below it live in registers; the third entry is
// prefetched from the stack RAM, so back-to-back pops need no stall.
// chars.ready is low only while a result waits and results.ready is low.
// Reset clears counters and flags; stack RAM contents are left as they are,
// since no entry is read before it is pushed.
// A last item delivers its result and clears the state for the next string.
`default_nettype none

module longest_balanced_bracket_run_top import lbbr_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int unsigned MAX_LEN     = MAX_LEN_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	lbbr_in_if.sink    chars,
	lbbr_out_if.source results
);

	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned POS_W = $clog2(MAX_LEN);      // a character position
	localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);  // position + 1, lengths

	logic accept;
	logic res_valid_q;

	// state
	logic [LEN_W-1:0] position_q;
	logic [LEN_W-1:0] barrier_q;     // last unmatched closer + 1
	logic [LEN_W-1:0] run_len_q;
	logic [LEN_W-1:0] run_start_q;
	logic [POS_W-1:0] run_end_q;
	logic             ovf_q;

	// step logic
	logic             sat;
	logic [POS_W-1:0] here;
	logic [LEN_W-1:0] here1;
	logic             is_open;
	logic             full;
	logic             empty;
	logic [CNT_W-1:0] count;
	logic [POS_W-1:0] below_top;
	logic [LEN_W-1:0] from;
	logic [LEN_W-1:0] len;
	logic             better;
	stack_cmd_t       cmd;

	logic [LEN_W-1:0] run_len_n;
	logic [LEN_W-1:0] run_start_n;
	logic [POS_W-1:0] run_end_n;
	logic [LEN_W-1:0] barrier_n;
	logic             ovf_n;

	// output register parts the two sides
	assign chars.ready = !res_valid_q || results.ready;
	assign accept      = chars.valid && chars.ready;

	always_comb begin
		sat     = position_q >= LEN_W'(MAX_LEN);
		here    = sat ? POS_W'(MAX_LEN - 1) : position_q[POS_W-1:0];
		here1   = LEN_W'(here) + LEN_W'(1);
		is_open = chars.ch == OPEN_BYTE;
		full    = count == CNT_W'(STACK_DEPTH);
		empty   = count == '0;

		cmd.push  = accept && is_open && !full;
		cmd.pop   = accept && !is_open && !empty;
		cmd.clear = accept && chars.last;

		// after the pop, the run starts past the new top, or at the barrier
		from   = (count > CNT_W'(1)) ? (LEN_W'(below_top) + LEN_W'(1)) : barrier_q;
		len    = (here1 >= from) ? (here1 - from) : '0;
		better = cmd.pop && (len > run_len_q);

		run_len_n   = better ? len : run_len_q;
		run_start_n = better ? from : run_start_q;
		run_end_n   = better ? here : run_end_q;
		barrier_n   = (!is_open && empty) ? here1 : barrier_q;
		ovf_n       = ovf_q || sat || (is_open && full);
	end

	lbbr_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.POS_W       (POS_W)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push_data (here),
		.count     (count),
		.below_top (below_top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= '0;
			barrier_q   <= '0;
			run_len_q   <= '0;
			run_start_q <= '0;
			run_end_q   <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				if (chars.last) begin
					position_q  <= '0;
					barrier_q   <= '0;
					run_len_q   <= '0;
					run_start_q <= '0;
					run_end_q   <= '0;
					ovf_q       <= 1'b0;
				end else begin
					position_q  <= sat ? position_q : (position_q + LEN_W'(1));
					barrier_q   <= barrier_n;
					run_len_q   <= run_len_n;
					run_start_q <= run_start_n;
					run_end_q   <= run_end_n;
					ovf_q       <= ovf_n;
				end
			end
		end
	end

	// result payload, shown before any end-of-string clear
	always_ff @(posedge clk) begin
		if (accept) begin
			results.best_len   <= BEST_LEN_W'(run_len_n);
			results.best_start <= BEST_POS_W'(run_start_n);
			results.best_end   <= BEST_POS_W'(run_end_n);
			results.done_res   <= chars.last;
			results.overflow   <= ovf_n;
		end
	end

	assign results.valid = res_valid_q;

endmodule

`default_nettype wire

>>> rtl/lbbr_check.sv
// Port-level checker for the bracket run block, bound to the top level.
`default_nettype none

module lbbr_check import lbbr_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [BEST_LEN_W-1:0] best_len
);

	// an accepted item always yields a result in the next cycle
	a_item_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

	// input side is never blocked while the output register is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_len_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(best_len))
		else $error("result changed while stalled");

endmodule

bind longest_balanced_bracket_run_top lbbr_check u_lbbr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.best_len  (results.best_len)
);

`default_nettype wire
